/* rtl/qs_pkg.sv */
package qs_pkg;

    // Store geometry
    localparam int DATA_W      = 32;
    localparam int MAX_ITEMS   = 64;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;
    localparam int RANGE_W     = 2 * IDX_W;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_POP,
        OP_RANGE,
        OP_PIV_RD,
        OP_PIV_TAKE,
        OP_SCAN_RD,
        OP_SKIP,
        OP_KEEP,
        OP_SWAP_RD,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_FIN_RD,
        OP_FIN_A,
        OP_FIN_B,
        OP_PUSH_HI,
        OP_PUSH_LO,
        OP_OUT_RD,
        OP_OUT_LD,
        OP_OUT_ADV
    } qs_op_t;

    typedef struct packed {
        qs_op_t op;
    } qs_cmd_t;

    typedef struct packed {
        logic count_lt2;   // fewer than two values held
        logic sp_zero;     // range stack empty
        logic range_bad;   // popped range holds fewer than two entries or is out of bounds
        logic j_eq_hi;     // scan reached the pivot
        logic next_eq_hi;  // pivot already in place
        logic next_eq_j;   // swap would be a no-op
        logic le;          // scanned value <= pivot
        logic out_last;    // result register holds the final value
    } qs_stat_t;

endpackage

/* rtl/quicksort_engine.sv */
// Quicksort engine. Takes signed 32-bit values, one item per cycle, into a
// 64-entry store until an item with tlast; further values of that set are
// dropped and every result of the set then carries tuser = 1. It then sorts
// the store in place, ascending, by Lomuto-partition quicksort whose pending
// index ranges sit on a small stack memory, and streams the sorted run out
// with tlast on the final result. All sorting traffic goes through the single
// read and single write port of the value store: each range is popped,
// checked and has its pivot read, every scanned entry is read and compared,
// a swap takes a read and two writes, and the range ends with a final pivot
// swap where needed and two stack pushes; each result is read from the store
// before it is offered. The input is not ready from the tlast item until the
// final result has been taken.
module quicksort_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic signed [qs_pkg::DATA_W-1:0] s_tdata,   // [31:0] price
    input  logic                             s_tlast,   // is_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic signed [qs_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                             m_tlast,   // last_out
    output logic [0:0]                       m_tuser    // [0] overflowed
);
    import qs_pkg::*;

    qs_cmd_t  cmd;
    qs_stat_t stat;
    logic     ovf;

    qs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    qs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .price        (s_tdata),
        .stat         (stat),
        .sorted_value (m_tdata),
        .last_out     (m_tlast),
        .overflowed   (ovf)
    );

    assign m_tuser = ovf;

    // Loading and unloading never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // A tlast item closes the input until the run is unloaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input reopened right after end of set");

    // Taking the final result reopens the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("engine did not return to loading after final result");

    // Hold an offered result steady until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("offered result changed before it was taken");

endmodule

/* rtl/qs_ctrl.sv */
module qs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    input  logic             m_tready,
    input  qs_pkg::qs_stat_t stat,
    output logic             s_tready,
    output logic             m_tvalid,
    output qs_pkg::qs_cmd_t  cmd
);
    import qs_pkg::*;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_POP   = 5'd2;
    localparam logic [4:0] S_RANGE = 5'd3;
    localparam logic [4:0] S_PIV   = 5'd4;
    localparam logic [4:0] S_PIVT  = 5'd5;
    localparam logic [4:0] S_SCAN  = 5'd6;
    localparam logic [4:0] S_CMP   = 5'd7;
    localparam logic [4:0] S_SWAPA = 5'd8;
    localparam logic [4:0] S_SWAPB = 5'd9;
    localparam logic [4:0] S_FINA  = 5'd10;
    localparam logic [4:0] S_FINB  = 5'd11;
    localparam logic [4:0] S_PUSHH = 5'd12;
    localparam logic [4:0] S_PUSHL = 5'd13;
    localparam logic [4:0] S_OUTRD = 5'd14;
    localparam logic [4:0] S_OUTLD = 5'd15;
    localparam logic [4:0] S_OUTV  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_OUTV);

    // Pick next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    cmd.op = OP_LOAD;
                    if (s_tlast)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (stat.sp_zero)
                begin
                    state_next = S_OUTRD;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.op     = OP_RANGE;
                state_next = stat.range_bad ? S_POP : S_PIV;
            end
            S_PIV:
            begin
                cmd.op     = OP_PIV_RD;
                state_next = S_PIVT;
            end
            S_PIVT:
            begin
                cmd.op     = OP_PIV_TAKE;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.j_eq_hi)
                begin
                    if (stat.next_eq_hi)
                    begin
                        state_next = S_PUSHH;
                    end
                    else
                    begin
                        cmd.op     = OP_FIN_RD;
                        state_next = S_FINA;
                    end
                end
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!stat.le)
                begin
                    cmd.op     = OP_SKIP;
                    state_next = S_SCAN;
                end
                else if (stat.next_eq_j)
                begin
                    cmd.op     = OP_KEEP;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.op     = OP_SWAP_RD;
                    state_next = S_SWAPA;
                end
            end
            S_SWAPA:
            begin
                cmd.op     = OP_SWAP_A;
                state_next = S_SWAPB;
            end
            S_SWAPB:
            begin
                cmd.op     = OP_SWAP_B;
                state_next = S_SCAN;
            end
            S_FINA:
            begin
                cmd.op     = OP_FIN_A;
                state_next = S_FINB;
            end
            S_FINB:
            begin
                cmd.op     = OP_FIN_B;
                state_next = S_PUSHH;
            end
            S_PUSHH:
            begin
                cmd.op     = OP_PUSH_HI;
                state_next = S_PUSHL;
            end
            S_PUSHL:
            begin
                cmd.op     = OP_PUSH_LO;
                state_next = S_POP;
            end
            S_OUTRD:
            begin
                cmd.op     = OP_OUT_RD;
                state_next = S_OUTLD;
            end
            S_OUTLD:
            begin
                cmd.op     = OP_OUT_LD;
                state_next = S_OUTV;
            end
            S_OUTV:
            begin
                if (m_tready)
                begin
                    cmd.op     = OP_OUT_ADV;
                    state_next = stat.out_last ? S_LOAD : S_OUTRD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

/* rtl/qs_datapath.sv */
module qs_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qs_pkg::qs_cmd_t                    cmd,
    input  logic signed [qs_pkg::DATA_W-1:0]   price,
    output qs_pkg::qs_stat_t                   stat,
    output logic signed [qs_pkg::DATA_W-1:0]   sorted_value,
    output logic                               last_out,
    output logic                               overflowed
);
    import qs_pkg::*;

    // Storage
    logic signed [DATA_W-1:0]  vs_mem [MAX_ITEMS];
    logic [RANGE_W-1:0]        stk_mem [STACK_DEPTH];

    logic signed [DATA_W-1:0]  vs_rdata_reg;
    logic [RANGE_W-1:0]        stk_rdata_reg;

    // Control registers
    logic [CNT_W-1:0]          count_reg;
    logic                      drop_reg;
    logic [SP_W-1:0]           sp_reg;
    logic [IDX_W-1:0]          k_reg;

    // Partition registers
    logic [IDX_W-1:0]          lo_reg;
    logic [IDX_W-1:0]          hi_reg;
    logic [IDX_W-1:0]          j_reg;
    logic [IDX_W-1:0]          next_reg;
    logic signed [DATA_W-1:0]  pivot_reg;
    logic signed [DATA_W-1:0]  vj_reg;

    // Result register
    logic signed [DATA_W-1:0]  out_data_reg;
    logic                      out_last_reg;
    logic                      out_ovf_reg;

    // Memory port controls
    logic                      vs_we;
    logic [IDX_W-1:0]          vs_waddr;
    logic signed [DATA_W-1:0]  vs_wdata;
    logic                      vs_re;
    logic [IDX_W-1:0]          vs_raddr;
    logic                      stk_we;
    logic [IDX_W-1:0]          stk_waddr;
    logic [RANGE_W-1:0]        stk_wdata;
    logic                      stk_re;
    logic [IDX_W-1:0]          stk_raddr;

    logic                      has_room;
    logic                      stk_room;
    logic                      push_hi_ok;
    logic                      push_lo_ok;
    logic [IDX_W-1:0]          pop_lo;
    logic [IDX_W-1:0]          pop_hi;
    logic [SP_W-1:0]           sp_dec;
    logic [CNT_W-1:0]          count_dec;

    assign has_room   = (count_reg < CNT_W'(MAX_ITEMS));
    assign stk_room   = (sp_reg < SP_W'(STACK_DEPTH));
    assign push_hi_ok = (({1'b0, next_reg} + CNT_W'(1)) < {1'b0, hi_reg});
    assign push_lo_ok = ({1'b0, next_reg} > ({1'b0, lo_reg} + CNT_W'(1)));
    assign pop_lo     = stk_rdata_reg[RANGE_W-1:IDX_W];
    assign pop_hi     = stk_rdata_reg[IDX_W-1:0];
    assign sp_dec     = sp_reg - SP_W'(1);
    assign count_dec  = count_reg - CNT_W'(1);

    // Status toward the controller
    assign stat.count_lt2  = (count_reg < CNT_W'(2));
    assign stat.sp_zero    = (sp_reg == '0);
    assign stat.range_bad  = (pop_lo >= pop_hi) || ({1'b0, pop_hi} >= count_reg);
    assign stat.j_eq_hi    = (j_reg == hi_reg);
    assign stat.next_eq_hi = (next_reg == hi_reg);
    assign stat.next_eq_j  = (next_reg == j_reg);
    assign stat.le         = (vs_rdata_reg <= pivot_reg);
    assign stat.out_last   = out_last_reg;

    assign sorted_value = out_data_reg;
    assign last_out     = out_last_reg;
    assign overflowed   = out_ovf_reg;

    // Route store and stack ports
    always_comb
    begin
        vs_we     = 1'b0;
        vs_waddr  = j_reg;
        vs_wdata  = vs_rdata_reg;
        vs_re     = 1'b0;
        vs_raddr  = j_reg;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[IDX_W-1:0];
        stk_wdata = {lo_reg, hi_reg};
        stk_re    = 1'b0;
        stk_raddr = sp_dec[IDX_W-1:0];
        unique case (cmd.op)
            OP_LOAD:
            begin
                vs_we    = has_room;
                vs_waddr = count_reg[IDX_W-1:0];
                vs_wdata = price;
            end
            OP_INIT:
            begin
                stk_we    = !stat.count_lt2;
                stk_waddr = '0;
                stk_wdata = {IDX_W'(0), count_dec[IDX_W-1:0]};
            end
            OP_POP:
            begin
                stk_re = 1'b1;
            end
            OP_PIV_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = hi_reg;
            end
            OP_SCAN_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = j_reg;
            end
            OP_SWAP_RD, OP_FIN_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = next_reg;
            end
            OP_SWAP_A:
            begin
                vs_we    = 1'b1;
                vs_waddr = j_reg;
                vs_wdata = vs_rdata_reg;
            end
            OP_SWAP_B:
            begin
                vs_we    = 1'b1;
                vs_waddr = next_reg;
                vs_wdata = vj_reg;
            end
            OP_FIN_A:
            begin
                vs_we    = 1'b1;
                vs_waddr = hi_reg;
                vs_wdata = vs_rdata_reg;
            end
            OP_FIN_B:
            begin
                vs_we    = 1'b1;
                vs_waddr = next_reg;
                vs_wdata = pivot_reg;
            end
            OP_PUSH_HI:
            begin
                stk_we    = push_hi_ok && stk_room;
                stk_wdata = {next_reg + IDX_W'(1), hi_reg};
            end
            OP_PUSH_LO:
            begin
                stk_we    = push_lo_ok && stk_room;
                stk_wdata = {lo_reg, next_reg - IDX_W'(1)};
            end
            OP_OUT_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = k_reg;
            end
            default:
            begin
                vs_we = 1'b0;
            end
        endcase
    end

    // Value store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (vs_we)
        begin
            vs_mem[vs_waddr] <= vs_wdata;
        end
        if (vs_re)
        begin
            vs_rdata_reg <= vs_mem[vs_raddr];
        end
    end

    // Range stack: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // Track set size, drop flag, stack pointer and output index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sp_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (has_room)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_reg <= 1'b1;
                    end
                end
                OP_INIT:
                begin
                    sp_reg <= stat.count_lt2 ? SP_W'(0) : SP_W'(1);
                    k_reg  <= '0;
                end
                OP_POP:
                begin
                    sp_reg <= sp_dec;
                end
                OP_PUSH_HI:
                begin
                    if (push_hi_ok && stk_room)
                    begin
                        sp_reg <= sp_reg + SP_W'(1);
                    end
                end
                OP_PUSH_LO:
                begin
                    if (push_lo_ok && stk_room)
                    begin
                        sp_reg <= sp_reg + SP_W'(1);
                    end
                end
                OP_OUT_ADV:
                begin
                    if (out_last_reg)
                    begin
                        count_reg <= '0;
                        drop_reg  <= 1'b0;
                        sp_reg    <= '0;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Partition indices, pivot and result register
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_RANGE:
            begin
                lo_reg <= pop_lo;
                hi_reg <= pop_hi;
            end
            OP_PIV_RD:
            begin
                j_reg    <= lo_reg;
                next_reg <= lo_reg;
            end
            OP_PIV_TAKE:
            begin
                pivot_reg <= vs_rdata_reg;
            end
            OP_SKIP:
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            OP_KEEP, OP_SWAP_B:
            begin
                j_reg    <= j_reg + IDX_W'(1);
                next_reg <= next_reg + IDX_W'(1);
            end
            OP_SWAP_RD:
            begin
                vj_reg <= vs_rdata_reg;
            end
            OP_OUT_LD:
            begin
                out_data_reg <= vs_rdata_reg;
                out_last_reg <= (({1'b0, k_reg} + CNT_W'(1)) == count_reg);
                out_ovf_reg  <= drop_reg;
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

endmodule

/* tb/sv/quicksort_engine_tb.sv */
`timescale 1ns / 1ps

module quicksort_engine_tb;

    import qs_pkg::*;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Value patterns for one set
    localparam int PAT_RANDOM  = 0;
    localparam int PAT_NARROW  = 1;
    localparam int PAT_EXTREME = 2;
    localparam int PAT_RAMP_UP = 3;
    localparam int PAT_RAMP_DN = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     dropped;
    } sorted_item_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic signed [DATA_W-1:0] m_tdata;
    logic                     m_tlast;
    logic [0:0]               m_tuser;

    // Predictor state: values held for the current set
    logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
    int                       held_cnt;
    bit                       held_drop;

    sorted_item_t sorted_q [$];
    int           err_cnt;
    bit           idle_on;
    bit           hold_req;
    int           hold_left;
    int           stall_left;

    quicksort_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Sort the held values in place: Lomuto partition, pivot at the top of
    // each range, pending ranges on an explicit stack
    function automatic void sort_held_vals();
        int                       lo_stk [MAX_ITEMS];
        int                       hi_stk [MAX_ITEMS];
        int                       sp;
        int                       lo;
        int                       hi;
        int                       p;
        logic signed [DATA_W-1:0] pivot;
        logic signed [DATA_W-1:0] tmp;
        if (held_cnt < 2)
            return;
        lo_stk[0] = 0;
        hi_stk[0] = held_cnt - 1;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            lo = lo_stk[sp];
            hi = hi_stk[sp];
            pivot = held_vals[hi];
            p = lo;
            for (int j = lo; j < hi; j++)
            begin
                // equal values go below the pivot
                if (held_vals[j] <= pivot)
                begin
                    tmp = held_vals[p];
                    held_vals[p] = held_vals[j];
                    held_vals[j] = tmp;
                    p++;
                end
            end
            tmp = held_vals[p];
            held_vals[p] = held_vals[hi];
            held_vals[hi] = tmp;
            if (p + 1 < hi)
            begin
                lo_stk[sp] = p + 1;
                hi_stk[sp] = hi;
                sp++;
            end
            if (p > lo + 1)
            begin
                lo_stk[sp] = lo;
                hi_stk[sp] = p - 1;
                sp++;
            end
        end
    endfunction

    // Take one accepted item into the predictor; on the marked item queue
    // the sorted run
    function automatic void accept_value(logic signed [DATA_W-1:0] price, logic mark);
        sorted_item_t res;
        if (held_cnt < MAX_ITEMS)
        begin
            held_vals[held_cnt] = price;
            held_cnt++;
        end
        else
            held_drop = 1'b1;
        if (!mark)
            return;
        sort_held_vals();
        for (int k = 0; k < held_cnt; k++)
        begin
            res.value   = held_vals[k];
            res.last    = (k == held_cnt - 1);
            res.dropped = held_drop;
            sorted_q.push_back(res);
        end
        held_cnt  = 0;
        held_drop = 1'b0;
    endfunction

    // Offer one item, with an occasional idle burst ahead of it
    task automatic send_item(input logic signed [DATA_W-1:0] price, input logic mark);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        s_tlast  <= mark;
        do
            @(posedge clk);
        while (!s_tready);
        accept_value(price, mark);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(int pat, int k, int n);
        logic signed [DATA_W-1:0] v;
        case (pat)
            PAT_NARROW:  v = $signed($urandom_range(0, 7)) - 4;
            PAT_EXTREME:
                case ($urandom_range(0, 5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 1;
                    3: v = VAL_MAX - 1;
                    4: v = 0;
                    default: v = -1;
                endcase
            PAT_RAMP_UP: v = k * 1000 - 20000;
            PAT_RAMP_DN: v = (n - k) * 1000 - 20000;
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_set(input int n, input int pat);
        for (int k = 0; k < n; k++)
            send_item(pick_value(pat, k, n), k == n - 1);
    endtask

    // Stop offering and wait for every queued result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
    endtask

    // Check each result against the oldest expectation, then choose tready
    always @(posedge clk)
    begin
        sorted_item_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                $display("%0t: expected no result, actual %0d last %0b ovf %0b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
                err_cnt++;
            end
            else
            begin
                exp_item = sorted_q.pop_front();
                if (m_tdata !== exp_item.value || m_tlast !== exp_item.last ||
                    m_tuser[0] !== exp_item.dropped)
                begin
                    $display("%0t: expected %0d last %0b ovf %0b, actual %0d last %0b ovf %0b",
                             $time, exp_item.value, exp_item.last, exp_item.dropped,
                             m_tdata, m_tlast, m_tuser[0]);
                    err_cnt++;
                end
            end
        end
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Extremes, single-item sets, duplicates and signed ordering
    task automatic test_directed();
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(0, 1'b1);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b1);
        send_item(3, 1'b0);
        send_item(1, 1'b0);
        send_item(2, 1'b1);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b1);
    endtask

    // Full store, dropped values, dropped marked item, presorted worst cases
    task automatic test_overflow();
        send_set(MAX_ITEMS + 2, PAT_NARROW);
        send_set(MAX_ITEMS, PAT_RAMP_UP);
        send_set(16, PAT_RAMP_DN);
        send_set(16, PAT_EXTREME);
    endtask

    // Mostly small sets with a randomly chosen value pattern, a few large ones
    task automatic test_random();
        int sent;
        int n;
        int sel;
        sent = 0;
        while (sent < 40)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 19);
            if (sel < 15)
                n = $urandom_range(1, 12);
            else if (sel < 19)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 3);
            send_set(n, $urandom_range(PAT_RANDOM, PAT_RAMP_DN));
            sent += n;
        end
        idle_on = 1'b1;
    endtask

    // Receiver holds off long enough that the input stalls; then the sender
    // pauses until the output is drained
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_set(20, PAT_RANDOM);
        send_set(7, PAT_NARROW);
        send_set(3, PAT_EXTREME);
        drain_results();
        repeat ($urandom_range(1, 10)) @(posedge clk);
        send_set(9, PAT_RANDOM);
    endtask

    // Full rate on both sides
    task automatic test_no_idle();
        idle_on = 1'b0;
        send_set(12, PAT_RANDOM);
        send_set(1, PAT_RANDOM);
        send_set(2, PAT_EXTREME);
        send_set(16, PAT_NARROW);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        held_cnt   = 0;
        held_drop  = 1'b0;
        err_cnt    = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_random();
        test_backpressure();
        test_no_idle();

        drain_results();
        repeat (300) @(posedge clk);
        if (err_cnt == 0)
            $display("[quicksort_engine] OK");
        else
            $display("[quicksort_engine] ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("[quicksort_engine] ERROR");
        $finish;
    end

endmodule
